/* hw/rtl/fno_pkg.sv */
`default_nettype none
package fno_pkg;

  localparam int unsigned BeatBytesDef = 8;
  localparam int unsigned MaxBeats     = 12;
  localparam int unsigned IdBits       = 64;
  localparam int unsigned ValBits      = 31;
  localparam int unsigned IdDigits     = 20;
  localparam int unsigned ValDigits    = 10;
  localparam int unsigned ConvCycles   = IdBits;
  localparam int unsigned ConstLen     = 43;

  localparam logic [8*ConstLen-1:0] ConstText = {
    "8=FIX.4.2", 8'h01, "9=",
    8'h01, "35=D", 8'h01, "11=",
    8'h01, "54=",
    8'h01, "38=",
    8'h01, "44=",
    8'h01, "40=2", 8'h01,
    "10=",
    8'h01
  };

  typedef struct packed {
    logic [63:0] order_id;
    logic [1:0]  side;
    logic [30:0] quantity;
    logic [30:0] price;
  } order_t;

  typedef struct packed {
    logic [63:0] data_bytes;
    logic [3:0]  byte_count;
    logic        last;
  } beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_FIN,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    SEG_HDR,
    SEG_BLEN,
    SEG_MID,
    SEG_ID,
    SEG_T54,
    SEG_SIDE,
    SEG_T38,
    SEG_QTY,
    SEG_T44,
    SEG_PRICE,
    SEG_T40,
    SEG_TRL,
    SEG_SUM,
    SEG_END
  } seg_e;

  typedef struct packed {
    logic       load;
    logic       conv;
    logic       conv_lo;
    logic       fin;
    logic       emit;
    logic       final_byte;
    seg_e       seg;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic [4:0] n_id;
    logic [3:0] n_qty;
    logic [3:0] n_price;
  } status_t;

  function automatic logic [5:0] seg_base(seg_e seg);
    logic [5:0] b;
    unique case (seg)
      SEG_HDR: b = 6'd0;
      SEG_MID: b = 6'd12;
      SEG_T54: b = 6'd21;
      SEG_T38: b = 6'd25;
      SEG_T44: b = 6'd29;
      SEG_T40: b = 6'd33;
      SEG_TRL: b = 6'd39;
      SEG_END: b = 6'd42;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] const_byte(logic [5:0] off);
    return ConstText[8*(ConstLen-1-32'(off)) +: 8];
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/fno_ctrl.sv */
`default_nettype none
module fno_ctrl
  import fno_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t st_i,
  output cmd_t         cmd_o
);

  state_e     state_q, state_d;
  seg_e       seg_q, seg_d;
  logic [4:0] idx_q, idx_d;
  logic [5:0] cnt_q, cnt_d;
  logic [4:0] seg_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seg_q   <= SEG_HDR;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      seg_q   <= seg_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    unique case (seg_q)
      SEG_HDR:   seg_len = 5'd12;
      SEG_BLEN:  seg_len = 5'd2;
      SEG_MID:   seg_len = 5'd9;
      SEG_ID:    seg_len = st_i.n_id;
      SEG_T54:   seg_len = 5'd4;
      SEG_SIDE:  seg_len = 5'd1;
      SEG_T38:   seg_len = 5'd4;
      SEG_QTY:   seg_len = {1'b0, st_i.n_qty};
      SEG_T44:   seg_len = 5'd4;
      SEG_PRICE: seg_len = {1'b0, st_i.n_price};
      SEG_T40:   seg_len = 5'd6;
      SEG_TRL:   seg_len = 5'd3;
      SEG_SUM:   seg_len = 5'd3;
      SEG_END:   seg_len = 5'd1;
      default:   seg_len = 5'd1;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    seg_d      = seg_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.seg  = seg_q;
    cmd_o.idx  = idx_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv    = 1'b1;
        cmd_o.conv_lo = (cnt_q >= 6'(ConvCycles - ValBits));
        cnt_d         = cnt_q + 6'd1;
        if (cnt_q == 6'(ConvCycles - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        seg_d     = SEG_HDR;
        idx_d     = '0;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (idx_q == seg_len - 5'd1) begin
            idx_d = '0;
            if (seg_q == SEG_END) begin
              cmd_o.final_byte = 1'b1;
              state_d          = ST_IDLE;
            end else begin
              seg_d = seg_e'(seg_q + 4'd1);
            end
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> state_q == ST_EMIT && st_i.out_free)
    else $error("byte emitted while output busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> idx_q < seg_len)
    else $error("segment index out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.final_byte |=> state_q == ST_IDLE)
    else $error("no return to idle after final byte");

endmodule
`default_nettype wire

/* hw/rtl/fno_dp.sv */
`default_nettype none
module fno_dp
  import fno_pkg::*;
#(
  parameter int unsigned BEAT_BYTES = BeatBytesDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire order_t in_data_i,
  input  wire cmd_t   cmd_i,
  output status_t     st_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output beat_t       out_data_o
);

  localparam int unsigned Beat     = (BEAT_BYTES > 8) ? 8 : ((BEAT_BYTES < 1) ? 1 : BEAT_BYTES);
  localparam int unsigned MaxBytes = MaxBeats * Beat;

  logic [IdBits-1:0]      id_sh_q;
  logic [ValBits-1:0]     qty_sh_q, price_sh_q;
  logic [4*IdDigits-1:0]  bcd_id_q;
  logic [4*ValDigits-1:0] bcd_qty_q, bcd_price_q;
  logic [1:0]             side_q;
  logic [4:0]             n_id_q;
  logic [3:0]             n_qty_q, n_price_q;
  logic [6:0]             blen_q;
  logic [7:0]             sum_q;
  logic [63:0]            pack_q;
  logic [3:0]             pcnt_q;
  logic [6:0]             sent_q;
  logic                   trunc_q;
  logic                   out_valid_q;
  beat_t                  out_q;

  logic                   out_free;
  logic [7:0]             cur_byte;
  logic [3:0]             digit;
  logic [4:0]             di;
  logic [3:0]             bl_t, bl_o, s_h, s_t, s_o;
  logic [7:0]             s_r;
  logic [63:0]            pack_new;
  logic [3:0]             pcnt_new;
  logic                   beat_done, last_byte;

  function automatic logic [4*IdDigits-1:0] dabble(logic [4*IdDigits-1:0] b, logic bit_in);
    logic [4*IdDigits-1:0] a;
    for (int k = 0; k < IdDigits; k++) begin
      a[4*k +: 4] = (b[4*k +: 4] >= 4'd5) ? b[4*k +: 4] + 4'd3 : b[4*k +: 4];
    end
    return {a[4*IdDigits-2:0], bit_in};
  endfunction

  function automatic logic [4:0] ndig(logic [4*IdDigits-1:0] b);
    logic [4:0] n;
    n = 5'd1;
    for (int k = 1; k < IdDigits; k++) begin
      if (b[4*k +: 4] != 4'd0) n = 5'(k + 1);
    end
    return n;
  endfunction

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    bl_t = '0;
    for (int k = 3; k <= 6; k++) begin
      if (blen_q >= 7'(10 * k)) bl_t = 4'(k);
    end
    bl_o = 4'(blen_q - 7'(bl_t) * 7'd10);
    s_h  = (sum_q >= 8'd200) ? 4'd2 : ((sum_q >= 8'd100) ? 4'd1 : 4'd0);
    s_r  = sum_q - 8'(s_h) * 8'd100;
    s_t  = '0;
    for (int k = 1; k <= 9; k++) begin
      if (s_r >= 8'(10 * k)) s_t = 4'(k);
    end
    s_o = 4'(s_r - 8'(s_t) * 8'd10);
  end

  always_comb begin
    di       = '0;
    digit    = '0;
    cur_byte = const_byte(seg_base(cmd_i.seg) + {1'b0, cmd_i.idx});
    unique case (cmd_i.seg)
      SEG_BLEN: begin
        digit    = (cmd_i.idx == 5'd0) ? bl_t : bl_o;
        cur_byte = {4'h3, digit};
      end
      SEG_ID: begin
        di       = n_id_q - 5'd1 - cmd_i.idx;
        digit    = bcd_id_q[4*di +: 4];
        cur_byte = {4'h3, digit};
      end
      SEG_SIDE: cur_byte = {6'b001100, side_q};
      SEG_QTY: begin
        di       = {1'b0, n_qty_q} - 5'd1 - cmd_i.idx;
        digit    = bcd_qty_q[4*di[3:0] +: 4];
        cur_byte = {4'h3, digit};
      end
      SEG_PRICE: begin
        di       = {1'b0, n_price_q} - 5'd1 - cmd_i.idx;
        digit    = bcd_price_q[4*di[3:0] +: 4];
        cur_byte = {4'h3, digit};
      end
      SEG_SUM: begin
        digit    = (cmd_i.idx == 5'd0) ? s_h : ((cmd_i.idx == 5'd1) ? s_t : s_o);
        cur_byte = {4'h3, digit};
      end
      default: ;
    endcase
  end

  always_comb begin
    pack_new  = pack_q | ({56'd0, cur_byte} << {pcnt_q, 3'b000});
    pcnt_new  = pcnt_q + 4'd1;
    last_byte = cmd_i.final_byte || (sent_q == 7'(MaxBytes - 1));
    beat_done = (pcnt_new == 4'(Beat)) || last_byte;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      id_sh_q     <= in_data_i.order_id;
      qty_sh_q    <= in_data_i.quantity;
      price_sh_q  <= in_data_i.price;
      side_q      <= in_data_i.side;
      bcd_id_q    <= '0;
      bcd_qty_q   <= '0;
      bcd_price_q <= '0;
    end else if (cmd_i.conv) begin
      id_sh_q  <= {id_sh_q[IdBits-2:0], 1'b0};
      bcd_id_q <= dabble(bcd_id_q, id_sh_q[IdBits-1]);
      if (cmd_i.conv_lo) begin
        qty_sh_q    <= {qty_sh_q[ValBits-2:0], 1'b0};
        price_sh_q  <= {price_sh_q[ValBits-2:0], 1'b0};
        bcd_qty_q   <= (4*ValDigits)'(dabble({40'd0, bcd_qty_q}, qty_sh_q[ValBits-1]));
        bcd_price_q <= (4*ValDigits)'(dabble({40'd0, bcd_price_q}, price_sh_q[ValBits-1]));
      end
    end
    if (cmd_i.fin) begin
      n_id_q    <= ndig(bcd_id_q);
      n_qty_q   <= 4'(ndig({40'd0, bcd_qty_q}));
      n_price_q <= 4'(ndig({40'd0, bcd_price_q}));
      blen_q    <= 7'd27 + 7'(ndig(bcd_id_q)) + 7'(ndig({40'd0, bcd_qty_q}))
                   + 7'(ndig({40'd0, bcd_price_q}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      pack_q      <= '0;
      pcnt_q      <= '0;
      sent_q      <= '0;
      trunc_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        sum_q   <= '0;
        pack_q  <= '0;
        pcnt_q  <= '0;
        sent_q  <= '0;
        trunc_q <= 1'b0;
      end else if (cmd_i.emit) begin
        if (cmd_i.seg < SEG_TRL) begin
          sum_q <= sum_q + cur_byte;
        end
        if (!trunc_q) begin
          sent_q <= sent_q + 7'd1;
          if (beat_done) begin
            out_valid_q      <= 1'b1;
            out_q.data_bytes <= pack_new;
            out_q.byte_count <= pcnt_new;
            out_q.last       <= last_byte;
            pack_q           <= '0;
            pcnt_q           <= '0;
            trunc_q          <= last_byte;
          end else begin
            pack_q <= pack_new;
            pcnt_q <= pcnt_new;
          end
        end
      end
    end
  end

  assign st_o.out_free = out_free;
  assign st_o.n_id     = n_id_q;
  assign st_o.n_qty    = n_qty_q;
  assign st_o.n_price  = n_price_q;
  assign out_valid_o   = out_valid_q;
  assign out_data_o    = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.byte_count != 4'd0 && out_q.byte_count <= 4'(Beat))
    else $error("beat byte count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> sent_q == 7'd0 && !trunc_q && pcnt_q == 4'd0)
    else $error("packer not cleared on new order");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcnt_q < 4'(Beat))
    else $error("partial beat overflow");

endmodule
`default_nettype wire

/* hw/rtl/fix_new_order_encoder.sv */
// flow: after the input transfer the order ID, quantity and price are converted to decimal
// bit-serially, then the message of 52 to 89 bytes is assembled one byte per cycle into
// beats while the output is free, stalling while a finished beat waits for out_ready_i;
// a new order is accepted only after the last byte of the previous message is emitted
// reset: asynchronous, clears controller, packer and output valid; no transfer pending
`default_nettype none
module fix_new_order_encoder
  import fno_pkg::*;
#(
  parameter int unsigned BEAT_BYTES = BeatBytesDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_ready_o,
  input  wire order_t in_data_i,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output beat_t       out_data_o
);

  cmd_t    cmd;
  status_t st;

  fno_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  fno_dp #(
    .BEAT_BYTES (BEAT_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none
module testbench;
  import fno_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  class beat_scoreboard;
    beat_t beats_q[$];
    int    mismatches;

    function int unsigned digit_count(logic [63:0] v);
      int unsigned n;
      n = 1;
      while (v >= 10) begin
        v = v / 10;
        n++;
      end
      return n;
    endfunction

    function void add_byte(ref byte unsigned msg[$], input byte unsigned b);
      msg.insert(msg.size(), b);
    endfunction

    function void push_text(ref byte unsigned msg[$], input string s);
      for (int i = 0; i < s.len(); i++) add_byte(msg, s[i]);
    endfunction

    function void push_dec(ref byte unsigned msg[$], input logic [63:0] v);
      byte unsigned dig[$];
      do begin
        dig.push_front(8'h30 + 8'(v % 10));
        v = v / 10;
      end while (v != 0);
      foreach (dig[i]) add_byte(msg, dig[i]);
    endfunction

    function void note_order(order_t o);
      byte unsigned msg[$];
      logic [7:0]   sum;
      int unsigned  body_len, pos, cnt, nbeats;
      beat_t        b;
      body_len = 5 + 4 + digit_count(o.order_id) + 4 + digit_count(64'(o.side))
               + 4 + digit_count(64'(o.quantity)) + 4 + digit_count(64'(o.price)) + 5;
      push_text(msg, "8=FIX.4.2"); add_byte(msg, 8'h01);
      push_text(msg, "9="); push_dec(msg, 64'(body_len)); add_byte(msg, 8'h01);
      push_text(msg, "35=D"); add_byte(msg, 8'h01);
      push_text(msg, "11="); push_dec(msg, o.order_id); add_byte(msg, 8'h01);
      push_text(msg, "54="); push_dec(msg, 64'(o.side)); add_byte(msg, 8'h01);
      push_text(msg, "38="); push_dec(msg, 64'(o.quantity)); add_byte(msg, 8'h01);
      push_text(msg, "44="); push_dec(msg, 64'(o.price)); add_byte(msg, 8'h01);
      push_text(msg, "40=2"); add_byte(msg, 8'h01);
      sum = 0;
      foreach (msg[i]) sum += msg[i];
      push_text(msg, "10=");
      add_byte(msg, 8'h30 + sum / 100);
      add_byte(msg, 8'h30 + (sum / 10) % 10);
      add_byte(msg, 8'h30 + sum % 10);
      add_byte(msg, 8'h01);
      pos = 0;
      nbeats = 0;
      while (pos < msg.size() && nbeats < MaxBeats) begin
        cnt = msg.size() - pos;
        if (cnt > 8) cnt = 8;
        b = '0;
        for (int i = 0; i < cnt; i++) b.data_bytes[8*i +: 8] = msg[pos + i];
        b.byte_count = 4'(cnt);
        pos += cnt;
        nbeats++;
        b.last = (pos >= msg.size()) || (nbeats == MaxBeats);
        beats_q.insert(beats_q.size(), b);
      end
    endfunction

    function void check_beat(beat_t got);
      beat_t exp_b;
      if (beats_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", got);
        return;
      end
      exp_b = beats_q.pop_front();
      if (got.data_bytes !== exp_b.data_bytes || got.byte_count !== exp_b.byte_count
          || got.last !== exp_b.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                   exp_b.data_bytes, exp_b.byte_count, exp_b.last,
                   got.data_bytes, got.byte_count, got.last);
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 20000;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_ready_o;
  order_t in_data_i = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  beat_t  out_data_o;

  beat_scoreboard sb = new();
  int  idle_cycles = 0;
  int  hold_cycles = 0;

  always #5 clk_i = ~clk_i;

  fix_new_order_encoder u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_order(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_beat(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand_id();
    case ($urandom_range(0, 3))
      0: return 64'($urandom_range(0, 99));
      1: return 64'($urandom);
      2: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [30:0] rand_val();
    case ($urandom_range(0, 2))
      0: return 31'($urandom_range(0, 999));
      1: return 31'($urandom) >> $urandom_range(0, 30);
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_order(logic [63:0] id, logic [1:0] side, logic [30:0] qty,
                            logic [30:0] price, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{order_id: id, side: side, quantity: qty, price: price};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin
    int stall;
    @(negedge clk_i);
    forever begin
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      @(negedge clk_i);
    end
  end

  initial begin
    int settle;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    send_order('0, 2'd1, '0, '0, 0);
    send_order('1, 2'd2, '1, '1, 0);
    send_order('1, 2'd0, '0, '1, 0);
    send_order('0, 2'd3, '1, '0, 0);
    send_order(64'd9999999999999999999, 2'd1, 31'd1000000000, 31'd999999999, 0);
    send_order(64'd10000000000000000000, 2'd2, 31'd9, 31'd10, 0);
    send_order(64'd12345, 2'd1, 31'd100, 31'd2500, 0);
    send_order(64'd7, 2'd2, 31'd1, 31'd1, 0);
    send_order(64'h5555_5555_5555_5555, 2'd1, 31'h2AAA_AAAA, 31'h5555_5555, 0);
    send_order(64'hAAAA_AAAA_AAAA_AAAA, 2'd2, 31'h5555_5555, 31'h2AAA_AAAA, 0);
    hold_cycles = 600;
    for (int i = 0; i < 6; i++) send_order(rand_id(), 2'($urandom_range(1, 2)),
                                           rand_val(), rand_val(), 1);
    for (int i = 0; i < 344; i++) begin
      send_order(rand_id(), ($urandom_range(0, 9) == 0) ? 2'($urandom) :
                 2'($urandom_range(1, 2)), rand_val(), rand_val(), 0);
    end
    in_valid_i <= 1'b0;
    settle = 0;
    while (sb.beats_q.size() != 0) @(posedge clk_i);
    while (settle < 300) begin
      @(posedge clk_i);
      settle++;
    end
    if (sb.mismatches == 0 && sb.beats_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
hw/rtl/fno_pkg.sv
hw/rtl/fno_ctrl.sv
hw/rtl/fno_dp.sv
hw/rtl/fix_new_order_encoder.sv
tb/sv/testbench.sv
